// ===== src/tfn_pkg.sv =====
// Package: widths, payload types and control struct for the triangle face normal unit
`default_nettype none
package tfn_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = 2 * COORD_WIDTH + 1;
    localparam int HALF_W  = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - HALF_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int Q_W     = NORMAL_FRAC_BITS + 2;
    localparam int T_W     = SQ_W + 2 * NORMAL_FRAC_BITS + 2;
    localparam int ROOT_W  = ((T_W > SUM_W + 2 * Q_W) ? T_W : (SUM_W + 2 * Q_W)) + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic                          last_triangle;
    } t_tri_in;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
        logic                           last_normal;
    } t_normal_out;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] neg;
        logic       degen;
    } t_ctl;

endpackage
`default_nettype wire

// ===== src/tfn_cross.sv =====
// Edge vectors, exact cross product, sign and magnitude split (3 stages)
`default_nettype none
module tfn_cross
    import tfn_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  wire                     i_valid,
    input  t_tri_in                 i_tri,
    output t_ctl                    o_ctl,
    output logic [2:0][MAG_W-1:0]   o_mag
);

    logic r_v1, r_v2, r_v3;
    logic r_l1, r_l2, r_l3;
    logic signed [DIFF_W-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PROD_W-1:0] r_p [6];
    logic [2:0]               r_neg;
    logic [2:0][MAG_W-1:0]    r_mag;

    logic signed [CROSS_W-1:0] n [3];
    logic signed [CROSS_W-1:0] n_abs [3];
    logic [2:0]                n_neg;
    logic [2:0][MAG_W-1:0]     n_mag;

    always_comb begin
        n[0] = CROSS_W'(r_p[0]) - CROSS_W'(r_p[1]);
        n[1] = CROSS_W'(r_p[2]) - CROSS_W'(r_p[3]);
        n[2] = CROSS_W'(r_p[4]) - CROSS_W'(r_p[5]);
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = n[i][CROSS_W-1];
            n_abs[i] = n_neg[i] ? -n[i] : n[i];
            n_mag[i] = n_abs[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l1 <= i_tri.last_triangle;
            r_ux <= DIFF_W'(i_tri.bx) - DIFF_W'(i_tri.ax);
            r_uy <= DIFF_W'(i_tri.by) - DIFF_W'(i_tri.ay);
            r_uz <= DIFF_W'(i_tri.bz) - DIFF_W'(i_tri.az);
            r_vx <= DIFF_W'(i_tri.cx) - DIFF_W'(i_tri.ax);
            r_vy <= DIFF_W'(i_tri.cy) - DIFF_W'(i_tri.ay);
            r_vz <= DIFF_W'(i_tri.cz) - DIFF_W'(i_tri.az);
            r_l2   <= r_l1;
            r_p[0] <= r_uy * r_vz;
            r_p[1] <= r_uz * r_vy;
            r_p[2] <= r_uz * r_vx;
            r_p[3] <= r_ux * r_vz;
            r_p[4] <= r_ux * r_vy;
            r_p[5] <= r_uy * r_vx;
            r_l3  <= r_l2;
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

    assign o_ctl.valid = r_v3;
    assign o_ctl.last  = r_l3;
    assign o_ctl.neg   = r_neg;
    assign o_ctl.degen = 1'b0;
    assign o_mag       = r_mag;

endmodule
`default_nettype wire

// ===== src/tfn_norm_sq.sv =====
// Squared length of the cross product and scaled squares per component (3 stages)
`default_nettype none
module tfn_norm_sq
    import tfn_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  t_ctl                    i_ctl,
    input  wire [2:0][MAG_W-1:0]    i_mag,
    output t_ctl                    o_ctl,
    output logic [SUM_W-1:0]        o_sum,
    output logic [2:0][ROOT_W-1:0]  o_rem
);

    t_ctl r_c4, r_c5, r_c6;
    logic [2*HI_W-1:0]        r_hh [3];
    logic [HI_W+HALF_W-1:0]   r_hl [3];
    logic [2*HALF_W-1:0]      r_ll [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [SUM_W-1:0]         r_sum;
    logic [2:0][ROOT_W-1:0]   r_rem;

    logic [SQ_W-1:0]  n_sq [3];
    logic [SUM_W-1:0] n_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = (SQ_W'(r_hh[i]) << (2 * HALF_W))
                    + (SQ_W'(r_hl[i]) << (HALF_W + 1))
                    + SQ_W'(r_ll[i]);
        end
        n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c4.valid <= 1'b0;
            r_c5.valid <= 1'b0;
            r_c6.valid <= 1'b0;
        end else if (i_adv) begin
            r_c4.valid <= i_ctl.valid;
            r_c5.valid <= r_c4.valid;
            r_c6.valid <= r_c5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c4.last  <= i_ctl.last;
            r_c4.neg   <= i_ctl.neg;
            r_c4.degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= i_mag[i][MAG_W-1:HALF_W] * i_mag[i][MAG_W-1:HALF_W];
                r_hl[i] <= i_mag[i][MAG_W-1:HALF_W] * i_mag[i][HALF_W-1:0];
                r_ll[i] <= i_mag[i][HALF_W-1:0] * i_mag[i][HALF_W-1:0];
            end
            r_c5.last  <= r_c4.last;
            r_c5.neg   <= r_c4.neg;
            r_c5.degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= n_sq[i];
            end
            r_c6.last  <= r_c5.last;
            r_c6.neg   <= r_c5.neg;
            r_c6.degen <= (n_sum == '0);
            r_sum      <= n_sum;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= ROOT_W'(r_sq[i]) << (2 * NORMAL_FRAC_BITS + 2);
            end
        end
    end

    assign o_ctl = r_c6;
    assign o_sum = r_sum;
    assign o_rem = r_rem;

endmodule
`default_nettype wire

// ===== src/tfn_root_step.sv =====
// One bit of the restoring root search q = floor(sqrt(T / s)) for all three lanes
`default_nettype none
module tfn_root_step
    import tfn_pkg::*;
#(
    parameter int J = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  t_ctl                    i_ctl,
    input  wire [SUM_W-1:0]         i_sum,
    input  wire [2:0][ROOT_W-1:0]   i_rem,
    input  wire [2:0][ROOT_W-1:0]   i_prod,
    input  wire [2:0][Q_W-1:0]      i_q,
    output t_ctl                    o_ctl,
    output logic [SUM_W-1:0]        o_sum,
    output logic [2:0][ROOT_W-1:0]  o_rem,
    output logic [2:0][ROOT_W-1:0]  o_prod,
    output logic [2:0][Q_W-1:0]     o_q
);

    t_ctl                   r_ctl;
    logic [SUM_W-1:0]       r_sum;
    logic [2:0][ROOT_W-1:0] r_rem, r_prod;
    logic [2:0][Q_W-1:0]    r_q;

    logic [ROOT_W-1:0]      s_ext;
    logic [ROOT_W-1:0]      sub [3];
    logic [2:0][ROOT_W-1:0] n_rem, n_prod;
    logic [2:0][Q_W-1:0]    n_q;

    always_comb begin
        s_ext = ROOT_W'(i_sum);
        for (int i = 0; i < 3; i++) begin
            sub[i] = (i_prod[i] << (J + 1)) + (s_ext << (2 * J));
            if (i_rem[i] >= sub[i]) begin
                n_rem[i]  = i_rem[i] - sub[i];
                n_prod[i] = i_prod[i] + (s_ext << J);
                n_q[i]    = i_q[i] | (Q_W'(1) << J);
            end else begin
                n_rem[i]  = i_rem[i];
                n_prod[i] = i_prod[i];
                n_q[i]    = i_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl.last  <= i_ctl.last;
            r_ctl.neg   <= i_ctl.neg;
            r_ctl.degen <= i_ctl.degen;
            r_sum       <= i_sum;
            r_rem       <= n_rem;
            r_prod      <= n_prod;
            r_q         <= n_q;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;
    assign o_q    = r_q;

endmodule
`default_nettype wire

// ===== src/triangle_face_normal.sv =====
// Top level: triangle face normal pipeline, cross product to rounded unit normal
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-----------------------
//   in      | i_valid | o_stall | i_tri  (t_tri_in)
//   out     | o_valid | i_stall | o_normal (t_normal_out)
//
// One transaction per cycle while not stalled; stages: 3 cross product,
// 3 squared length, 16 root bit steps of 3 parallel lanes, 1 output register.
// Synchronous active-low reset clears all stage valid bits.
// When the output register holds a transaction and i_stall is high, the whole
// pipeline freezes and o_stall is raised.
`default_nettype none
module triangle_face_normal
    import tfn_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  t_tri_in      i_tri,
    output logic         o_valid,
    input  wire          i_stall,
    output t_normal_out  o_normal
);

    logic adv;
    logic r_out_valid;
    t_normal_out r_out;

    t_ctl                   c_ctl;
    logic [2:0][MAG_W-1:0]  c_mag;

    t_ctl                   st_ctl  [Q_W+1];
    logic [SUM_W-1:0]       st_sum  [Q_W+1];
    logic [2:0][ROOT_W-1:0] st_rem  [Q_W+1];
    logic [2:0][ROOT_W-1:0] st_prod [Q_W+1];
    logic [2:0][Q_W-1:0]    st_q    [Q_W+1];

    logic [Q_W:0]                   k    [3];
    logic signed [NORMAL_WIDTH-1:0] comp [3];

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .o_ctl   (c_ctl),
        .o_mag   (c_mag)
    );

    tfn_norm_sq u_norm_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (c_ctl),
        .i_mag   (c_mag),
        .o_ctl   (st_ctl[0]),
        .o_sum   (st_sum[0]),
        .o_rem   (st_rem[0])
    );

    assign st_prod[0] = '0;
    assign st_q[0]    = '0;

    for (genvar g = 0; g < Q_W; g++) begin : g_root
        tfn_root_step #(
            .J (Q_W - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (st_ctl[g]),
            .i_sum   (st_sum[g]),
            .i_rem   (st_rem[g]),
            .i_prod  (st_prod[g]),
            .i_q     (st_q[g]),
            .o_ctl   (st_ctl[g+1]),
            .o_sum   (st_sum[g+1]),
            .o_rem   (st_rem[g+1]),
            .o_prod  (st_prod[g+1]),
            .o_q     (st_q[g+1])
        );
    end

    // k = largest odd o <= q gives (o + 1) / 2 = (q + 1) >> 1
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            k[i] = ((Q_W + 1)'(st_q[Q_W][i]) + (Q_W + 1)'(1)) >> 1;
            if (st_ctl[Q_W].degen) begin
                comp[i] = '0;
            end else if (st_ctl[Q_W].neg[i]) begin
                comp[i] = -$signed(k[i][NORMAL_WIDTH-1:0]);
            end else begin
                comp[i] = $signed(k[i][NORMAL_WIDTH-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= st_ctl[Q_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.normal_x    <= comp[0];
            r_out.normal_y    <= comp[1];
            r_out.normal_z    <= comp[2];
            r_out.degenerate  <= st_ctl[Q_W].degen;
            r_out.last_normal <= st_ctl[Q_W].last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_normal = r_out;

endmodule
`default_nettype wire

// ===== verif/triangle_face_normal_tb.sv =====
// Testbench: triangle face normal unit, directed then random triangles checked
// against an exact integer normal calculation, under varied stall patterns
`default_nettype none
module triangle_face_normal_tb
    import tfn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT = 1 << NORMAL_FRAC_BITS;
    localparam int RAND_PER_PHASE = 480;

    typedef struct {
        t_tri_in     tri_v;
        bit          typed;
        t_normal_out normal;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_tri_in     i_tri;
    logic        o_valid;
    logic        i_stall;
    t_normal_out o_normal;

    t_normal_out pending_normals[$];
    int          errors;
    int          tri_sent;
    int          normals_seen;
    int          degen_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;

    triangle_face_normal u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_tri    (i_tri),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_normal (o_normal)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [NORMAL_WIDTH-1:0] unit_component(longint c,
                                                                      logic [127:0] sum_sq);
        logic [127:0] mag;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] odd;
        longint       lo;
        longint       hi;
        longint       k;
        mag = (c < 0) ? -c : c;
        lhs = (mag * mag) << (2 * NORMAL_FRAC_BITS + 2);
        lo = 0;
        hi = UNIT;
        while (lo < hi) begin
            k = lo + (hi - lo + 1) / 2;
            odd = 2 * k - 1;
            rhs = odd * odd * sum_sq;
            if (lhs >= rhs) lo = k;
            else hi = k - 1;
        end
        return NORMAL_WIDTH'((c < 0) ? -lo : lo);
    endfunction

    function automatic t_normal_out face_normal(t_tri_in t);
        longint       ux, uy, uz, vx, vy, vz, nx, ny, nz;
        logic [127:0] sum_sq;
        logic [127:0] m;
        t_normal_out  r;
        ux = longint'(t.bx) - longint'(t.ax);
        uy = longint'(t.by) - longint'(t.ay);
        uz = longint'(t.bz) - longint'(t.az);
        vx = longint'(t.cx) - longint'(t.ax);
        vy = longint'(t.cy) - longint'(t.ay);
        vz = longint'(t.cz) - longint'(t.az);
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        r = '0;
        r.last_normal = t.last_triangle;
        if (nx == 0 && ny == 0 && nz == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        m = 128'((nx < 0) ? -nx : nx);
        sum_sq = m * m;
        m = 128'((ny < 0) ? -ny : ny);
        sum_sq = sum_sq + m * m;
        m = 128'((nz < 0) ? -nz : nz);
        sum_sq = sum_sq + m * m;
        r.normal_x = unit_component(nx, sum_sq);
        r.normal_y = unit_component(ny, sum_sq);
        r.normal_z = unit_component(nz, sum_sq);
        return r;
    endfunction

    function automatic t_tri_in make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, bit last);
        t_tri_in t;
        t.ax = COORD_WIDTH'(ax); t.ay = COORD_WIDTH'(ay); t.az = COORD_WIDTH'(az);
        t.bx = COORD_WIDTH'(bx); t.by = COORD_WIDTH'(by); t.bz = COORD_WIDTH'(bz);
        t.cx = COORD_WIDTH'(cx); t.cy = COORD_WIDTH'(cy); t.cz = COORD_WIDTH'(cz);
        t.last_triangle = last;
        return t;
    endfunction

    function automatic t_normal_out make_normal(int x, int y, int z, bit degen, bit last);
        t_normal_out n;
        n.normal_x = NORMAL_WIDTH'(x);
        n.normal_y = NORMAL_WIDTH'(y);
        n.normal_z = NORMAL_WIDTH'(z);
        n.degenerate = degen;
        n.last_normal = last;
        return n;
    endfunction

    function automatic int rand_coord(int span);
        if (span == 0) return $urandom_range(65535) - 32768;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic t_tri_in random_tri();
        t_tri_in t;
        int      span;
        int      mode;
        int      k;
        mode = $urandom_range(9);
        span = (mode < 5) ? 0 : (mode < 8) ? 8 : 300;
        t = make_tri(rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span),
                     1'($urandom_range(1)));
        if (mode == 9) begin
            // collinear: c on the line through a and b
            k = $urandom_range(6) - 3;
            t.cx = COORD_WIDTH'(t.ax + k * (t.bx - t.ax));
            t.cy = COORD_WIDTH'(t.ay + k * (t.by - t.ay));
            t.cz = COORD_WIDTH'(t.az + k * (t.bz - t.az));
        end
        return t;
    endfunction

    task automatic send_tri(t_tri_in t, bit typed, t_normal_out n);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_tri   <= t;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        pending_normals.push_back(typed ? n : face_normal(t));
        tri_sent++;
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(negedge i_clk) begin
        t_normal_out exp_n;
        if (i_rst_n && o_valid && !i_stall) begin
            normals_seen++;
            if (o_normal.degenerate) degen_seen++;
            if (pending_normals.size() == 0) begin
                $display("%0t: unexpected normal %h", $time, o_normal);
                errors++;
            end else begin
                exp_n = pending_normals.pop_front();
                if (o_normal.normal_x !== exp_n.normal_x)
                    $display("%0t: normal_x exp %0d got %0d", $time,
                             exp_n.normal_x, o_normal.normal_x);
                if (o_normal.normal_y !== exp_n.normal_y)
                    $display("%0t: normal_y exp %0d got %0d", $time,
                             exp_n.normal_y, o_normal.normal_y);
                if (o_normal.normal_z !== exp_n.normal_z)
                    $display("%0t: normal_z exp %0d got %0d", $time,
                             exp_n.normal_z, o_normal.normal_z);
                if (o_normal.degenerate !== exp_n.degenerate)
                    $display("%0t: degenerate exp %b got %b", $time,
                             exp_n.degenerate, o_normal.degenerate);
                if (o_normal.last_normal !== exp_n.last_normal)
                    $display("%0t: last_normal exp %b got %b", $time,
                             exp_n.last_normal, o_normal.last_normal);
                if (o_normal !== exp_n) errors++;
            end
        end
    end

    initial begin
        t_row rows[$];
        int   phase;
        int   wait_cycles;
        errors = 0; tri_sent = 0; normals_seen = 0; degen_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_tri   = '0;

        rows.push_back('{make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_normal(0, 0, 0, 1, 0)});
        rows.push_back('{make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0), 1,
                         make_normal(0, 0, UNIT, 0, 0)});
        rows.push_back('{make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 1), 1,
                         make_normal(0, 0, -UNIT, 0, 1)});
        rows.push_back('{make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1,
                         make_normal(UNIT, 0, 0, 0, 0)});
        rows.push_back('{make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0), 1,
                         make_normal(0, UNIT, 0, 0, 0)});
        rows.push_back('{make_tri(5, 5, 5, 6, 6, 6, 9, 9, 9, 1), 1,
                         make_normal(0, 0, 0, 1, 1)});
        rows.push_back('{make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                  -32768, -32768, -32768, 0), 1, make_normal(0, 0, 0, 1, 0)});
        rows.push_back('{make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                  -32768, 32767, -32768, 0), 1, make_normal(0, 0, UNIT, 0, 0)});
        rows.push_back('{make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                  32767, -32768, 32767, 1), 0, '0});
        rows.push_back('{make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                  32767, 32767, -32768, 0), 0, '0});
        rows.push_back('{make_tri(32767, -32768, 0, -32768, 0, 32767,
                                  0, 32767, -32768, 1), 0, '0});
        rows.push_back('{make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1, 0), 0, '0});
        rows.push_back('{make_tri(0, 0, 0, 3, 0, 0, 0, 4, 5, 0), 0, '0});
        rows.push_back('{make_tri(0, 0, 0, 1, 2, 0, 0, 0, 2, 0), 0, '0});
        rows.push_back('{make_tri(7, -3, 2, -1, 4, 9, 3, 3, -8, 1), 0, '0});
        rows.push_back('{make_tri(0, 0, 0, 32767, 1, 0, 32767, 0, 1, 0), 0, '0});
        rows.push_back('{make_tri(0, 0, 0, 1, 0, 0, 1, 1, 32767, 0), 0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_tri(rows[r].tri_v, rows[r].typed, rows[r].normal);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_left = 200; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            repeat (RAND_PER_PHASE) send_tri(random_tri(), 0, '0);
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_normals.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_normals.size() != 0) begin
            $display("%0d normals never arrived", pending_normals.size());
            errors++;
        end

        $display("covered %0d triangles, %0d normals checked, %0d degenerate",
                 tri_sent, normals_seen, degen_seen);
        $display("stall patterns: free run, long output hold, sender gaps, receiver stalls, mixed");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
